// ===== design/byte_stream_mix_hash_top_macros.svh =====
// Assertion macros used by the checker of the mix hash block.
`ifndef BYTE_STREAM_MIX_HASH_TOP_MACROS_SVH
`define BYTE_STREAM_MIX_HASH_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BSMH_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bsmh check failed");

// Next-cycle implication, quiet during reset.
`define BSMH_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bsmh check failed");

// Next-cycle implication that also holds across reset.
`define BSMH_ASSERT_NEXT_RST(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("bsmh check failed");

`endif

// ===== design/bsmh_pkg.sv =====
// Types and constants of the byte stream mix hash block.
`timescale 1ns / 1ps
package bsmh_pkg;

  localparam logic [63:0] MIX_MUL_A     = 64'h9E3779B185EBCA87;
  localparam logic [63:0] MIX_MUL_B     = 64'h165667B19E3779F9;
  localparam logic [63:0] SEED_AT_RESET = 64'hC2B2AE3D27D4EB4F;
  localparam int unsigned ROT_A     = 49;
  localparam int unsigned ROT_B     = 24;
  localparam int unsigned MIX_SHIFT = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREMIX,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_XSHIFT,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_ABSORB,
    ST_TAIL,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BYTE,
    OP_PREMIX,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_XSHIFT,
    OP_ABSORB,
    OP_TAIL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_b;      // second multiply constant
    logic   cfg_write;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_full;     // seven bytes pending
    logic cnt_zero;
    logic fin;          // message end seen
    logic out_free;     // output register can take a result
  } dp_status_t;

endpackage

// ===== design/byte_stream_mix_hash_top.sv =====
// Top level of the byte stream mix hash block.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | sink      | in_valid / in_ready  | data_byte, has_byte, last
//   out     | source    | out_valid / out_ready| hash_value
//   cfg     | sink      | cfg_valid / cfg_ready| start_seed
//
// A byte beat that does not complete a word is taken while idle. The eighth byte of a
// word runs the word mix: premix, two 64-bit multiplies of three partial products each
// on the one shared 32x32 multiplier, a shift-xor and the accumulator update. A last
// beat adds a tail step per chunk (up to three chunks of 4, 2 and 1 bytes, each mixed
// the same way), a final tail step and the emit. Reset is synchronous and needs no
// clearing pass; the seed comes back as 0xC2B2AE3D27D4EB4F. A stalled result
// waits in the output register while byte beats keep flowing; only the next emit waits.
`timescale 1ns / 1ps
module byte_stream_mix_hash_top
  import bsmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] start_seed
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bsmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .has_byte  (has_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .status    (status),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bsmh_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .start_seed (start_seed),
    .out_ready  (out_ready),
    .status     (status),
    .out_valid  (out_valid),
    .hash_value (hash_value)
  );

endmodule

// ===== design/bsmh_datapath.sv =====
// Datapath: byte packing, shared 32x32 multiplier, accumulator and result register.
`timescale 1ns / 1ps
module bsmh_datapath
  import bsmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  input  logic [63:0] start_seed,
  input  logic        out_ready,
  output dp_status_t  status,
  output logic        out_valid,
  output logic [63:0] hash_value
);

  logic [63:0] seed, seed_next;
  logic [63:0] acc, acc_next;
  logic [55:0] pend, pend_next;
  logic [2:0]  cnt, cnt_next;
  logic        fin, fin_next;
  logic [63:0] word, word_next;
  logic [63:0] v, v_next;
  logic [63:0] prod, prod_next;
  logic        out_valid_next;
  logic [63:0] hash_next;

  logic [31:0] mul_a, mul_k;
  logic [63:0] mul_p;
  logic [63:0] k_sel;
  logic [63:0] prod_xs;

  assign k_sel   = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
  assign prod_xs = prod ^ (prod >> MIX_SHIFT);

  // One 32x32 partial product per cycle; only the low 64 bits of the full product matter.
  always_comb begin
    mul_a = v[31:0];
    mul_k = k_sel[31:0];
    case (cmd.op)
      OP_MUL1: mul_k = k_sel[63:32];
      OP_MUL2: mul_a = v[63:32];
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_k);

  always_comb begin
    seed_next      = seed;
    acc_next       = acc;
    pend_next      = pend;
    cnt_next       = cnt;
    fin_next       = fin;
    word_next      = word;
    v_next         = v;
    prod_next      = prod;
    hash_next      = hash_value;
    out_valid_next = out_valid && !out_ready;
    case (cmd.op)
      OP_BYTE: begin
        fin_next = last;
        if (has_byte) begin
          if (cnt == 3'd7) begin
            word_next = {data_byte, pend};
            pend_next = '0;
            cnt_next  = '0;
          end else begin
            pend_next = pend | (56'(data_byte) << {cnt, 3'b000});
            cnt_next  = cnt + 3'd1;
          end
        end
      end
      OP_PREMIX: v_next = word ^ {word[ROT_A-1:0], word[63:ROT_A]}
                               ^ {word[ROT_B-1:0], word[63:ROT_B]};
      OP_MUL0:   prod_next = mul_p;
      OP_MUL1,
      OP_MUL2:   prod_next = prod + {mul_p[31:0], 32'd0};
      OP_XSHIFT: v_next = prod_xs;
      OP_ABSORB: acc_next = (word + acc) ^ prod_xs;
      OP_TAIL: begin
        // take a 4-byte, then 2-byte, then 1-byte chunk
        if (cnt[2]) begin
          word_next = {32'd0, pend[31:0]};
          pend_next = pend >> 32;
          cnt_next  = cnt - 3'd4;
        end else if (cnt[1]) begin
          word_next = {48'd0, pend[15:0]};
          pend_next = pend >> 16;
          cnt_next  = cnt - 3'd2;
        end else begin
          word_next = {56'd0, pend[7:0]};
          pend_next = '0;
          cnt_next  = '0;
        end
      end
      OP_EMIT: begin
        hash_next      = acc;
        out_valid_next = 1'b1;
        acc_next       = seed;
        pend_next      = '0;
        cnt_next       = '0;
        fin_next       = 1'b0;
      end
      default: ;
    endcase
    if (cmd.cfg_write) begin
      seed_next = start_seed;
      acc_next  = start_seed;
      pend_next = '0;
      cnt_next  = '0;
      fin_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_AT_RESET;
      acc       <= SEED_AT_RESET;
      pend      <= '0;
      cnt       <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      seed      <= seed_next;
      acc       <= acc_next;
      pend      <= pend_next;
      cnt       <= cnt_next;
      fin       <= fin_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word       <= word_next;
    v          <= v_next;
    prod       <= prod_next;
    hash_value <= hash_next;
  end

  assign status.cnt_full = (cnt == 3'd7);
  assign status.cnt_zero = (cnt == 3'd0);
  assign status.fin      = fin;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== design/bsmh_ctrl.sv =====
// Controller: sequences byte beats, the word mix steps, the tail and the result.
`timescale 1ns / 1ps
module bsmh_ctrl
  import bsmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       has_byte,
  input  logic       last,
  input  logic       cfg_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output logic       cfg_ready,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   in_fire;

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_byte && status.cnt_full) begin
            state_next = ST_PREMIX;
          end else if (last) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_PREMIX: state_next = ST_MA0;
      ST_MA0:    state_next = ST_MA1;
      ST_MA1:    state_next = ST_MA2;
      ST_MA2:    state_next = ST_XSHIFT;
      ST_XSHIFT: state_next = ST_MB0;
      ST_MB0:    state_next = ST_MB1;
      ST_MB1:    state_next = ST_MB2;
      ST_MB2:    state_next = ST_ABSORB;
      ST_ABSORB: state_next = status.fin ? ST_TAIL : ST_IDLE;
      ST_TAIL:   state_next = status.cnt_zero ? ST_EMIT : ST_PREMIX;
      ST_EMIT:   state_next = status.out_free ? ST_IDLE : ST_EMIT;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.mul_b     = 1'b0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    unique case (state)
      ST_IDLE:   cmd.op = in_fire ? OP_BYTE : OP_NONE;
      ST_PREMIX: cmd.op = OP_PREMIX;
      ST_MA0:    cmd.op = OP_MUL0;
      ST_MA1:    cmd.op = OP_MUL1;
      ST_MA2:    cmd.op = OP_MUL2;
      ST_XSHIFT: cmd.op = OP_XSHIFT;
      ST_MB0: begin
        cmd.op    = OP_MUL0;
        cmd.mul_b = 1'b1;
      end
      ST_MB1: begin
        cmd.op    = OP_MUL1;
        cmd.mul_b = 1'b1;
      end
      ST_MB2: begin
        cmd.op    = OP_MUL2;
        cmd.mul_b = 1'b1;
      end
      ST_ABSORB: cmd.op = OP_ABSORB;
      ST_TAIL:   cmd.op = status.cnt_zero ? OP_NONE : OP_TAIL;
      ST_EMIT:   cmd.op = status.out_free ? OP_EMIT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/bsmh_checker.sv =====
// Port-level checker for the mix hash block and its bind to the top level.
`timescale 1ns / 1ps
`include "byte_stream_mix_hash_top_macros.svh"
module bsmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        has_byte,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] hash_value,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_valid && in_ready;
  assign cfg_beat = cfg_valid && cfg_ready;

  // a waiting result holds its value
  `BSMH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hash_value))
  // a seed write never shares a cycle with a byte beat
  `BSMH_ASSERT_SAME(a_cfg_excl, clk, rst, cfg_valid, !in_ready)
  // an idle beat leaves the controller idle, ready for a seed write
  `BSMH_ASSERT_NEXT(a_idle_beat, clk, rst, in_beat && !has_byte && !last, cfg_ready)
  // a closing beat always leaves the block busy on the tail or the word mix
  `BSMH_ASSERT_NEXT(a_last_busy, clk, rst, in_beat && last && !cfg_beat, !in_ready && !cfg_ready)
  // reset drops any pending result
  `BSMH_ASSERT_NEXT_RST(a_rst_out, clk, rst, !out_valid)

endmodule

bind byte_stream_mix_hash_top bsmh_checker u_bsmh_checker (.*);
